FILE: src/cobs_frame_decoder_macros.svh
// assertion macros for the cobs frame decoder
// needs clk, and for CFD_ASSERT also rst_n, in the scope where a macro is used
`ifndef COBS_FRAME_DECODER_MACROS_SVH
`define COBS_FRAME_DECODER_MACROS_SVH

// checked only while out of reset
`define CFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/cfd_pkg.sv
// shared constants and types for the cobs frame decoder
// no dependencies
package cfd_pkg;

    localparam logic [7:0]  CODE_FULL      = 8'hFF;
    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    // frame status codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_CAPACITY  = 2'd2;

    // one result word
    typedef struct packed {
        logic        frame_end;
        logic        byte_valid;
        logic [1:0]  status;
        logic [15:0] out_length;
        logic [7:0]  out_byte;
    } result_t;

endpackage

FILE: src/cobs_frame_decoder.sv
// cobs frame decoder top level: byte-stream decode, error latch, output skid buffer
// depends on cfd_pkg and cobs_frame_decoder_macros.svh
//
// channel   | dir | tdata                                   | tuser      | tlast
// ----------+-----+-----------------------------------------+------------+-----------
// s_axis    | in  | [7:0] in_byte                           | -          | in_last
// m_axis    | out | [7:0] out_byte [9:8] status             | byte_valid | frame_end
//           |     | [25:10] out_length [31:26] zero         |            |
// cfg       | in  | cfg_wdata = capacity, taken when cfg_we | -          | -
//
// one encoded byte per cycle while s_axis_tready is high: the decode is a single
// pass from the frame state registers and the input word into the result register
// each result is registered, into the result register or, while that is held, the skid entry
// rst_n is asynchronous: frame state cleared, capacity back to 65535
// a two-entry output buffer (result plus skid) keeps s_axis_tready registered;
// it drops only once both entries hold words
// bytes that make no result (swallowed or code with no restored zero) cost no output slot

module cobs_frame_decoder
    import cfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status, [25:10] out_length
    output logic        m_axis_tuser,   // byte_valid
    output logic        m_axis_tlast,   // frame_end

    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata       // capacity
);

    // configuration
    logic [15:0] capacity_reg;

    // frame state
    logic [7:0]  bytes_left_reg,       bytes_left_next;
    logic        prev_code_full_reg,   prev_code_full_next;
    logic        in_frame_reg,         in_frame_next;
    logic [15:0] decoded_count_reg,    decoded_count_next;
    logic [1:0]  error_code_reg,       error_code_next;
    logic        capacity_pending_reg, capacity_pending_next;

    // output buffer
    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg,        out_next;
    result_t skid_reg,       skid_next;

    logic    in_accept;
    logic    out_take;
    logic    res_valid;
    result_t res;

    // per-byte scratch
    logic        emit;
    logic [7:0]  emit_byte;
    logic [7:0]  left_dec;
    logic        zero_due;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;

    // decode one byte against the frame state
    always_comb
    begin
        bytes_left_next       = bytes_left_reg;
        prev_code_full_next   = prev_code_full_reg;
        in_frame_next         = in_frame_reg;
        decoded_count_next    = decoded_count_reg;
        error_code_next       = error_code_reg;
        capacity_pending_next = capacity_pending_reg;
        emit                  = 1'b0;
        emit_byte             = 8'd0;
        left_dec              = bytes_left_reg - 8'd1;
        zero_due              = in_frame_reg && !prev_code_full_reg;
        res                   = '0;
        res_valid             = 1'b0;

        if (in_accept)
        begin
            if (error_code_reg == ERR_NONE)
            begin
                if (bytes_left_reg == 8'd0)
                begin
                    // code byte, maybe preceded by the restored zero
                    if (zero_due)
                    begin
                        if (decoded_count_reg >= capacity_reg)
                        begin
                            error_code_next = ERR_CAPACITY;
                        end
                        else
                        begin
                            emit               = 1'b1;
                            decoded_count_next = decoded_count_reg + 16'd1;
                        end
                    end
                    if (error_code_next == ERR_NONE)
                    begin
                        if (s_axis_tdata == 8'd0)
                        begin
                            error_code_next = ERR_MALFORMED;
                        end
                        else
                        begin
                            in_frame_next       = 1'b1;
                            bytes_left_next     = s_axis_tdata - 8'd1;
                            prev_code_full_next = (s_axis_tdata == CODE_FULL);
                            if (s_axis_tlast && s_axis_tdata != 8'd1)
                            begin
                                error_code_next = ERR_MALFORMED;
                            end
                        end
                    end
                end
                else
                begin
                    // data byte
                    if (!capacity_pending_reg && decoded_count_reg < capacity_reg)
                    begin
                        emit               = 1'b1;
                        emit_byte          = s_axis_tdata;
                        decoded_count_next = decoded_count_reg + 16'd1;
                    end
                    else
                    begin
                        capacity_pending_next = 1'b1;
                    end
                    bytes_left_next = left_dec;
                    if (s_axis_tlast && left_dec != 8'd0)
                    begin
                        error_code_next = ERR_MALFORMED;
                    end
                    else if (left_dec == 8'd0 && capacity_pending_next)
                    begin
                        error_code_next = ERR_CAPACITY;
                    end
                end
            end

            res_valid      = emit || s_axis_tlast;
            res.out_byte   = emit_byte;
            res.byte_valid = emit;
            res.frame_end  = s_axis_tlast;
            res.status     = s_axis_tlast ? error_code_next : ERR_NONE;
            res.out_length = (s_axis_tlast && error_code_next == ERR_NONE)
                             ? decoded_count_next : 16'd0;

            // frame over: back to a clean start
            if (s_axis_tlast)
            begin
                bytes_left_next       = 8'd0;
                prev_code_full_next   = 1'b0;
                in_frame_next         = 1'b0;
                decoded_count_next    = 16'd0;
                error_code_next       = ERR_NONE;
                capacity_pending_next = 1'b0;
            end
        end
    end

    // result register with skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg         <= CAPACITY_RESET;
            bytes_left_reg       <= 8'd0;
            prev_code_full_reg   <= 1'b0;
            in_frame_reg         <= 1'b0;
            decoded_count_reg    <= 16'd0;
            error_code_reg       <= ERR_NONE;
            capacity_pending_reg <= 1'b0;
            out_valid_reg        <= 1'b0;
            skid_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            bytes_left_reg       <= bytes_left_next;
            prev_code_full_reg   <= prev_code_full_next;
            in_frame_reg         <= in_frame_next;
            decoded_count_reg    <= decoded_count_next;
            error_code_reg       <= error_code_next;
            capacity_pending_reg <= capacity_pending_next;
            out_valid_reg        <= out_valid_next;
            skid_valid_reg       <= skid_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.out_length, out_reg.status, out_reg.out_byte};
    assign m_axis_tuser  = out_reg.byte_valid;
    assign m_axis_tlast  = out_reg.frame_end;

    `include "cobs_frame_decoder_macros.svh"

    // skid entry only ever fills behind a held result
    `CFD_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid word without result word")
    // a reported length only on a clean frame end
    `CFD_ASSERT(a_length_clean_end, (m_axis_tvalid && m_axis_tdata[25:10] != 16'd0) |-> (m_axis_tlast && m_axis_tdata[9:8] == ERR_NONE), "length on non-final or failed word")
    // no byte flagged means a zero byte field
    `CFD_ASSERT(a_idle_byte_zero, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'd0), "stray data without byte_valid")
    // last byte of a frame leaves a clean frame state
    `CFD_ASSERT(a_frame_cleared, (in_accept && s_axis_tlast) |=> (!in_frame_reg && error_code_reg == ERR_NONE && decoded_count_reg == 16'd0 && bytes_left_reg == 8'd0), "frame state not cleared at frame end")

endmodule

FILE: test/cobs_frame_decoder_tb.sv
// self-checking testbench for cobs_frame_decoder: directed and random encoded frames
// depends on cfd_pkg and the cobs_frame_decoder top level, nothing else
`timescale 1ns / 100ps

module cobs_frame_decoder_tb;
    import cfd_pkg::*;

    localparam int DRAIN_CYCLES = 8;    // drain margin for the registered result and the two-word output buffer
    localparam int MAX_REPORTS  = 10;

    // clock and reset
    logic        clk = 1'b0;
    logic        rst_n;

    // input stream: one encoded byte per word
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;      // [7:0] in_byte
    logic        s_axis_tlast = 1'b0;       // in_last

    // output stream: one decoded word
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;              // [7:0] out_byte, [9:8] status, [25:10] out_length
    logic        m_axis_tuser;              // byte_valid
    logic        m_axis_tlast;              // frame_end

    // capacity register
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    // decoder model state, mirrors the block's frame registers
    logic [15:0] capacity_reg = CAPACITY_RESET;
    logic [7:0]  frame_bytes_left = 8'd0;
    logic        frame_prev_full = 1'b0;
    logic        frame_open = 1'b0;
    logic [15:0] frame_count = 16'd0;
    logic [1:0]  frame_error = ERR_NONE;
    logic        frame_cap_pending = 1'b0;

    // decoded words still owed by the block, oldest first
    result_t     decoded_words_q[$];
    result_t     want_word;

    // encoded frame being built for sending
    logic [7:0]  frame_bytes[$];

    // idling controls
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;

    // bookkeeping
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          words_checked = 0;
    int          frames_ok = 0;
    int          frames_malformed = 0;
    int          frames_capacity = 0;
    int          input_stall_cycles = 0;

    cobs_frame_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // decode one accepted encoded byte and queue the word it should produce
    task automatic decode_cobs_byte(input logic [7:0] b, input logic last);
        logic        emit;
        logic [7:0]  ob;
        result_t     word;
        emit = 1'b0;
        ob   = 8'h00;
        if (frame_error == ERR_NONE)
        begin
            if (frame_bytes_left == 8'd0)
            begin
                // code byte: restore the zero that closed the previous block
                if (frame_open && !frame_prev_full)
                begin
                    if (frame_count >= capacity_reg)
                        frame_error = ERR_CAPACITY;
                    else
                    begin
                        emit        = 1'b1;
                        ob          = 8'h00;
                        frame_count = frame_count + 16'd1;
                    end
                end
                if (frame_error == ERR_NONE)
                begin
                    if (b == 8'h00)
                        frame_error = ERR_MALFORMED;
                    else
                    begin
                        frame_open       = 1'b1;
                        frame_bytes_left = b - 8'd1;
                        frame_prev_full  = (b == CODE_FULL);
                        // frame ends with data bytes still owed
                        if (last && frame_bytes_left != 8'd0)
                            frame_error = ERR_MALFORMED;
                    end
                end
            end
            else
            begin
                // data byte: passed through unless past capacity
                if (!frame_cap_pending && frame_count < capacity_reg)
                begin
                    emit        = 1'b1;
                    ob          = b;
                    frame_count = frame_count + 16'd1;
                end
                else
                    frame_cap_pending = 1'b1;
                frame_bytes_left = frame_bytes_left - 8'd1;
                // truncation wins over a pending capacity error
                if (last && frame_bytes_left != 8'd0)
                    frame_error = ERR_MALFORMED;
                else if (frame_bytes_left == 8'd0 && frame_cap_pending)
                    frame_error = ERR_CAPACITY;
            end
        end

        if (emit || last)
        begin
            word.out_byte   = emit ? ob : 8'h00;
            word.byte_valid = emit;
            word.frame_end  = last;
            word.status     = last ? frame_error : ERR_NONE;
            word.out_length = (last && frame_error == ERR_NONE) ? frame_count : 16'd0;
            decoded_words_q.push_back(word);
        end

        if (last)
        begin
            frame_bytes_left  = 8'd0;
            frame_prev_full   = 1'b0;
            frame_open        = 1'b0;
            frame_count       = 16'd0;
            frame_error       = ERR_NONE;
            frame_cap_pending = 1'b0;
        end
    endtask

    // receiver: random stalls, or a long hold-off counted here in cycles
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // checker: compare each output word with the oldest expectation, then
    // model any input word taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !s_axis_tready)
                input_stall_cycles++;
            if (m_axis_tvalid && m_axis_tready)
            begin
                words_checked++;
                if (decoded_words_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected word at %0t: tdata %h tuser %b tlast %b",
                                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    want_word = decoded_words_q.pop_front();
                    if (m_axis_tdata[7:0]   !== want_word.out_byte   ||
                        m_axis_tdata[9:8]   !== want_word.status     ||
                        m_axis_tdata[25:10] !== want_word.out_length ||
                        m_axis_tdata[31:26] !== 6'd0                 ||
                        m_axis_tuser        !== want_word.byte_valid ||
                        m_axis_tlast        !== want_word.frame_end)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("mismatch at %0t, pad bits %h",
                                     $time, m_axis_tdata[31:26]);
                            $display("  expected byte %h valid %b end %b status %0d length %0d",
                                     want_word.out_byte, want_word.byte_valid,
                                     want_word.frame_end, want_word.status,
                                     want_word.out_length);
                            $display("  actual   byte %h valid %b end %b status %0d length %0d",
                                     m_axis_tdata[7:0], m_axis_tuser, m_axis_tlast,
                                     m_axis_tdata[9:8], m_axis_tdata[25:10]);
                        end
                    end
                    if (want_word.frame_end)
                    begin
                        case (want_word.status)
                            ERR_NONE:      frames_ok++;
                            ERR_MALFORMED: frames_malformed++;
                            default:       frames_capacity++;
                        endcase
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_cobs_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    // offer one encoded byte, with random idle cycles first, and wait until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // send the whole of frame_bytes, last flag on its final byte
    task automatic send_frame_bytes();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // stop offering and wait until every owed word has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (decoded_words_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // capacity write, only ever called with the block idle
    task automatic set_capacity(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        capacity_reg = value;
    endtask

    // random frame: mostly well-formed chains of blocks, some with a zero
    // code, some cut short, and some plain noise
    task automatic build_random_frame();
        int kind;
        int nblocks;
        int zero_at;
        int code;
        int r;
        int i;
        int j;
        int keep;
        frame_bytes.delete();
        kind    = $urandom_range(0, 99);
        nblocks = $urandom_range(1, 4);
        zero_at = (kind >= 80 && kind < 87) ? $urandom_range(0, nblocks - 1) : -1;
        for (i = 0; i < nblocks; i++)
        begin
            r = $urandom_range(0, 99);
            if (i == zero_at)
                code = 0;
            else if (r < 3)
                code = 255;
            else if (r < 10)
                code = $urandom_range(13, 64);
            else
                code = $urandom_range(1, 12);
            frame_bytes.push_back(code[7:0]);
            for (j = 1; j < code; j++)
                frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        // cut short, usually inside a block
        if (kind >= 87 && kind < 94 && frame_bytes.size() > 1)
        begin
            keep = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > keep)
                void'(frame_bytes.pop_back());
        end
        // noise
        if (kind >= 94)
        begin
            frame_bytes.delete();
            r = $urandom_range(1, 8);
            for (i = 0; i < r; i++)
                frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // empty frame, data bytes at both extremes, restored zero at frame end
    task automatic test_plain_frames();
        wait_drained();
        set_capacity(CAPACITY_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        frame_bytes = '{8'h01};
        send_frame_bytes();
        frame_bytes = '{8'h03, 8'h00, 8'hFF};
        send_frame_bytes();
        frame_bytes = '{8'h02, 8'hAA, 8'h01};
        send_frame_bytes();
    endtask

    // zero code after a block (restored zero comes first), truncated block,
    // zero code as the very first byte
    task automatic test_malformed_frames();
        frame_bytes = '{8'h02, 8'h55, 8'h00, 8'h33, 8'h44};
        send_frame_bytes();
        frame_bytes = '{8'h04, 8'h11};
        send_frame_bytes();
        frame_bytes = '{8'h00};
        send_frame_bytes();
    endtask

    // block overrun, restored zero past capacity, capacity of zero
    task automatic test_capacity_limits();
        wait_drained();
        set_capacity(16'd1);
        frame_bytes = '{8'h03, 8'h11, 8'h22};
        send_frame_bytes();
        frame_bytes = '{8'h02, 8'h11, 8'h01};
        send_frame_bytes();
        wait_drained();
        set_capacity(16'd0);
        frame_bytes = '{8'h01};
        send_frame_bytes();
        frame_bytes = '{8'h02, 8'h7E};
        send_frame_bytes();
    endtask

    // long receiver hold-off while bytes keep coming, then a mid-frame pause
    // until every owed word has come out
    task automatic test_output_backpressure();
        int i;
        wait_drained();
        set_capacity(CAPACITY_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        frame_bytes.delete();
        frame_bytes.push_back(8'h40);
        for (i = 1; i < 64; i++)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(8'h05);
        for (i = 0; i < 4; i++)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        hold_request = 150;
        for (i = 0; i < 40; i++)
            send_byte(frame_bytes[i], 1'b0);
        wait_drained();
        for (i = 40; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // one random phase at fixed idling and capacity
    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input logic [15:0] cap, input int n_items);
        int start;
        wait_drained();
        set_capacity(cap);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            build_random_frame();
            send_frame_bytes();
        end
    endtask

    // random frames through every idling pattern and a spread of capacities
    task automatic test_random_traffic();
        run_random_phase(0, 0, CAPACITY_RESET, 400);
        run_random_phase(71, 0, 16'($urandom_range(0, 40)), 350);
        run_random_phase(0, 71, 16'($urandom_range(0, 65535)), 350);
        run_random_phase(32, 32, 16'($urandom_range(1, 24)), 400);
        run_random_phase(0, 0, 16'd0, 100);
    endtask

    initial
    begin
        // reset held low, then released on a rising edge
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_frames();
        test_malformed_frames();
        test_capacity_limits();
        test_output_backpressure();
        test_random_traffic();

        wait_drained();
        $display("sent %0d encoded bytes, checked %0d decoded words, input stalled %0d cycles",
                 items_sent, words_checked, input_stall_cycles);
        $display("frames closed: %0d ok, %0d malformed, %0d over capacity",
                 frames_ok, frames_malformed, frames_capacity);
        if (mismatch_count == 0 && decoded_words_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // overall time limit, far above the slowest correct run
    initial
    begin
        #4_000_000;
        $display("run timed out");
        $display("FAILED: results differ");
        $finish;
    end

endmodule
